// ===== rtl/pbwt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbwt_pkg
// Shared types and field widths of the positional prefix-order column update.
// ----------------------------------------------------------------------------
package pbwt_pkg;

    localparam int HAP_W       = 6;   // haplotype index, row index, rank fields
    localparam int DIV_W       = 16;  // divergence site value
    localparam int CNT_W       = 7;   // haplotype_count register and zero count
    localparam int IN_TDATA_W  = 8;   // haplotype, allele, zero pad
    localparam int OUT_TDATA_W = 48;  // six result fields, zero pad

    localparam logic [CNT_W-1:0] HAP_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0] HAP_COUNT_MIN   = 7'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic allele_wr;
        logic walk_start;
        logic walk_issue;
        logic emit_read;
        logic emit_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_last;
        logic pipe_empty;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/pbwt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbwt_ctrl
// Sequencer for allele loading, order walk and result emission.
// ----------------------------------------------------------------------------
module pbwt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tlast,
    input  wire pbwt_pkg::t_dp_sts i_sts,
    output pbwt_pkg::t_dp_cmd      o_cmd,
    output logic                   o_s_tready
);
    import pbwt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.allele_wr = 1'b1;
                    if (i_s_tlast) begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk_issue = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_read = 1'b1;
                    n_state         = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                o_cmd.emit_load = 1'b1;
                n_state = i_sts.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pbwt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbwt_datapath
// Column memories, three-stage order walk, partition buffers, output register.
// ----------------------------------------------------------------------------
module pbwt_datapath #(
    parameter int MAX_HAPLOTYPES = 64,
    parameter int MAX_SITES      = 65535
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pbwt_pkg::t_dp_cmd                 i_cmd,
    output pbwt_pkg::t_dp_sts                      o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [pbwt_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  wire logic [pbwt_pkg::HAP_W-1:0]        i_haplotype,
    input  wire logic                              i_allele,
    output logic [pbwt_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready
);
    import pbwt_pkg::*;

    localparam int IW = $clog2(MAX_HAPLOTYPES);
    localparam int CW = $clog2(MAX_HAPLOTYPES + 1);

    // configuration
    logic [CNT_W-1:0] r_hap_count;
    logic [CW-1:0]    w_m;
    logic [CW-1:0]    r_m;

    // memories
    logic              r_allele_mem [MAX_HAPLOTYPES];
    logic [IW-1:0]     r_ord_mem    [MAX_HAPLOTYPES];
    logic [DIV_W-1:0]  r_div_mem    [MAX_HAPLOTYPES];
    logic [IW-1:0]     r_zord_mem   [MAX_HAPLOTYPES];
    logic [DIV_W-1:0]  r_zdiv_mem   [MAX_HAPLOTYPES];
    logic [IW-1:0]     r_oord_mem   [MAX_HAPLOTYPES];
    logic [DIV_W-1:0]  r_odiv_mem   [MAX_HAPLOTYPES];
    logic [2*IW-1:0]   r_rank_mem   [MAX_HAPLOTYPES];
    logic [MAX_HAPLOTYPES-1:0] r_ord_valid;

    // site and walk state
    logic [DIV_W-1:0]  r_site;
    logic [DIV_W-1:0]  w_start;
    logic [CW-1:0]     r_wi;
    logic [CW-1:0]     r_zeros;
    logic [CW-1:0]     r_ones;
    logic [CW-1:0]     w_pos;
    logic [DIV_W-1:0]  r_p;
    logic [DIV_W-1:0]  r_q;
    logic [DIV_W-1:0]  w_pm;
    logic [DIV_W-1:0]  w_qm;

    // walk stage B and C
    logic              r_bv;
    logic [IW-1:0]     r_b_ord;
    logic [DIV_W-1:0]  r_b_div;
    logic              r_b_vld;
    logic [IW-1:0]     r_b_idx;
    logic [IW-1:0]     w_b_id;
    logic [DIV_W-1:0]  w_b_dv;
    logic              r_cv;
    logic [IW-1:0]     r_c_id;
    logic [DIV_W-1:0]  r_c_dv;
    logic              r_c_allele;

    // emission
    logic [CW-1:0]     r_er;
    logic [CW-1:0]     w_oi;
    logic              r_sel_one;
    logic [IW-1:0]     r_rz_ord;
    logic [DIV_W-1:0]  r_rz_div;
    logic [IW-1:0]     r_ro_ord;
    logic [DIV_W-1:0]  r_ro_div;
    logic [2*IW-1:0]   r_rrank;
    logic [IW-1:0]     w_e_id;
    logic [DIV_W-1:0]  w_e_div;

    // output register
    logic              r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data;
    logic              r_o_last;

    always_comb begin
        if (r_hap_count < HAP_COUNT_MIN) begin
            w_m = CW'(2);
        end else if (int'(r_hap_count) > MAX_HAPLOTYPES) begin
            w_m = CW'(MAX_HAPLOTYPES);
        end else begin
            w_m = CW'(r_hap_count);
        end
    end

    assign w_start = (r_site >= DIV_W'(MAX_SITES)) ? DIV_W'(MAX_SITES) : r_site + 1'b1;
    assign w_pos   = r_zeros + r_ones;
    assign w_pm    = (r_c_dv > r_p) ? r_c_dv : r_p;
    assign w_qm    = (r_c_dv > r_q) ? r_c_dv : r_q;
    assign w_b_id  = r_b_vld ? r_b_ord : r_b_idx;
    assign w_b_dv  = r_b_vld ? r_b_div : '0;
    assign w_oi    = r_er - r_zeros;
    assign w_e_id  = r_sel_one ? r_ro_ord : r_rz_ord;
    assign w_e_div = r_sel_one ? r_ro_div : r_rz_div;

    always_comb begin
        o_sts.walk_last  = (r_wi == r_m - 1'b1);
        o_sts.pipe_empty = !r_bv && !r_cv;
        o_sts.emit_last  = (r_er == r_m - 1'b1);
        o_sts.out_free   = !r_o_valid || i_m_tready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hap_count <= HAP_COUNT_RESET;
            r_site      <= '0;
            r_ord_valid <= '0;
            r_bv        <= 1'b0;
            r_cv        <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hap_count <= i_cfg_wdata;
            end
            if (i_cmd.walk_start) begin
                r_site <= w_start;
            end
            if (i_cmd.emit_load) begin
                r_ord_valid[r_er[IW-1:0]] <= 1'b1;
            end
            r_bv <= i_cmd.walk_issue;
            r_cv <= r_bv;
            if (i_cmd.emit_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // allele load
    always_ff @(posedge i_clk) begin
        if (i_cmd.allele_wr && (int'(i_haplotype) < MAX_HAPLOTYPES)) begin
            r_allele_mem[i_haplotype[IW-1:0]] <= i_allele;
        end
    end

    // walk stage A: read stored order and divergence
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_m  <= w_m;
            r_wi <= '0;
        end else if (i_cmd.walk_issue) begin
            r_wi <= r_wi + 1'b1;
        end
        if (i_cmd.walk_issue) begin
            r_b_ord <= r_ord_mem[r_wi[IW-1:0]];
            r_b_div <= r_div_mem[r_wi[IW-1:0]];
            r_b_vld <= r_ord_valid[r_wi[IW-1:0]];
            r_b_idx <= r_wi[IW-1:0];
        end
    end

    // walk stage B: fetch the allele of that haplotype
    always_ff @(posedge i_clk) begin
        if (r_bv) begin
            r_c_allele <= r_allele_mem[w_b_id];
            r_c_id     <= w_b_id;
            r_c_dv     <= w_b_dv;
        end
    end

    // walk stage C: partition and running maxima
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_zeros <= '0;
            r_ones  <= '0;
            r_p     <= w_start;
            r_q     <= w_start;
        end else if (r_cv) begin
            r_rank_mem[w_pos[IW-1:0]] <= {r_ones[IW-1:0], r_zeros[IW-1:0]};
            if (!r_c_allele) begin
                r_zord_mem[r_zeros[IW-1:0]] <= r_c_id;
                r_zdiv_mem[r_zeros[IW-1:0]] <= w_pm;
                r_zeros <= r_zeros + 1'b1;
                r_p     <= '0;
                r_q     <= w_qm;
            end else begin
                r_oord_mem[r_ones[IW-1:0]] <= r_c_id;
                r_odiv_mem[r_ones[IW-1:0]] <= w_qm;
                r_ones <= r_ones + 1'b1;
                r_q    <= '0;
                r_p    <= w_pm;
            end
        end
    end

    // emission: read buffers, then load output and write back the new order
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_er <= '0;
        end else if (i_cmd.emit_load) begin
            r_er <= r_er + 1'b1;
        end
        if (i_cmd.emit_read) begin
            r_rz_ord  <= r_zord_mem[r_er[IW-1:0]];
            r_rz_div  <= r_zdiv_mem[r_er[IW-1:0]];
            r_ro_ord  <= r_oord_mem[w_oi[IW-1:0]];
            r_ro_div  <= r_odiv_mem[w_oi[IW-1:0]];
            r_rrank   <= r_rank_mem[r_er[IW-1:0]];
            r_sel_one <= (r_er >= r_zeros);
        end
        if (i_cmd.emit_load) begin
            r_ord_mem[r_er[IW-1:0]] <= w_e_id;
            r_div_mem[r_er[IW-1:0]] <= w_e_div;
            r_o_data <= {{(OUT_TDATA_W - 47){1'b0}},
                         HAP_W'(r_rrank[2*IW-1:IW]),
                         HAP_W'(r_rrank[IW-1:0]),
                         CNT_W'(r_zeros),
                         w_e_div,
                         HAP_W'(w_e_id),
                         HAP_W'(r_er)};
            r_o_last <= (r_er == r_m - 1'b1);
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule
`default_nettype wire

// ===== rtl/pbwt_column_update.sv =====
`default_nettype none
// Flow: after the end-of-column transaction the walk reads one stored row per cycle
// through a three-stage read pipeline, then emission handles each row as a registered
// buffer read followed by a load of the output register, waiting while the output
// register still holds a stalled row.
// Reset: synchronous, active low; the stored order reads as identity and the stored
// divergence as zero through per-row valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// pbwt_column_update
// Positional prefix-order and divergence update of a haplotype panel, one
// site per column: load alleles, stably partition the order, emit each row.
// ----------------------------------------------------------------------------
module pbwt_column_update #(
    parameter int MAX_HAPLOTYPES = 64,
    parameter int MAX_SITES      = 65535
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration: haplotype_count
    input  wire logic                               i_cfg_we,
    input  wire logic [pbwt_pkg::CNT_W-1:0]         i_cfg_wdata,
    // allele stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [5:0] haplotype, [6] allele, [7] zero
    input  wire logic [pbwt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // end_of_column
    input  wire logic                               s_axis_tlast,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [5:0] row, [11:6] haplotype_id, [27:12] divergence, [34:28] zero_count,
    // [40:35] zeros_before, [46:41] ones_before, [47] zero
    output logic [pbwt_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // last
    output logic                                    m_axis_tlast
);
    import pbwt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence the column: accept alleles, walk the order, emit one row at a time.
    // Input stays closed from the end-of-column transaction until the final row has
    // been loaded into the output register; that row may still wait downstream
    // while the next column loads.
    pbwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (s_axis_tready)
    );

    // Hold the column, the stored order and divergence, the zero and one buffers
    // filled by the walk, and the output register.
    pbwt_datapath #(
        .MAX_HAPLOTYPES (MAX_HAPLOTYPES),
        .MAX_SITES      (MAX_SITES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_haplotype (s_axis_tdata[HAP_W-1:0]),
        .i_allele    (s_axis_tdata[HAP_W]),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready)
    );

endmodule
`default_nettype wire

// ===== rtl/pbwt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbwt_checker
// Port-level checks of the column update, bound to the top level.
// ----------------------------------------------------------------------------
module pbwt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result transaction changed");

    // the end-of-column transaction closes the input for the walk
    a_walk_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open right after end of column");

    // no allele is taken while a column is still being emitted
    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during column emission");

    // zero count stays fixed within a column
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
            |=> !m_axis_tvalid || (m_axis_tdata[34:28] == $past(m_axis_tdata[34:28])))
        else $error("zero count changed within a column");

    // ranks above a row add up to its position
    a_ranks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[40:35] + m_axis_tdata[46:41]) == m_axis_tdata[5:0])
        else $error("zero and one ranks do not sum to row");

endmodule

bind pbwt_column_update pbwt_checker u_pbwt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== dv/tb_pbwt_column_update.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pbwt_column_update
// Self-checking bench for the prefix-order column update. Allele columns are
// streamed in, and every emitted row is compared against a bench-side
// prediction of the stable zero/one partition and the divergence update.
// Random stalls are applied on both streams.
// ----------------------------------------------------------------------------
module tb_pbwt_column_update;
    import pbwt_pkg::*;

    localparam int MAX_HAPLOTYPES = 64;
    localparam int MAX_SITES      = 65535;
    localparam int RANDOM_ITEMS   = 300;
    localparam int SETTLE_CYCLES  = 12;       // block is back in load well within this
    localparam int CYCLE_LIMIT    = 1500000;

    // one emitted row, field order as on the bus
    typedef struct packed {
        logic [HAP_W-1:0] row;
        logic [HAP_W-1:0] hap_id;
        logic [DIV_W-1:0] div;
        logic [CNT_W-1:0] zero_count;
        logic [HAP_W-1:0] zeros_before;
        logic [HAP_W-1:0] ones_before;
        logic             is_last;
    } t_pbwt_row;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONE,
        FILL_SPARSE
    } t_fill;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]        i_cfg_wdata   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [5:0] haplotype, [6] allele, [7] zero
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    // end_of_column
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [5:0] row, [11:6] haplotype_id, [27:12] divergence, [34:28] zero_count,
    // [40:35] zeros_before, [46:41] ones_before, [47] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // last
    logic                    m_axis_tlast;

    // bench copy of the block state
    logic             allele_mem [MAX_HAPLOTYPES];
    logic [HAP_W-1:0] order_mem  [MAX_HAPLOTYPES];
    logic [DIV_W-1:0] div_mem    [MAX_HAPLOTYPES];
    int unsigned      site_cnt;
    logic [CNT_W-1:0] hap_count_reg;

    t_pbwt_row pending_rows [$];

    int  mismatch_count = 0;
    int  allele_count   = 0;
    int  rows_seen      = 0;
    int  cfg_writes     = 0;
    int  cycle_count    = 0;
    int  sink_stall     = 0;
    bit  src_idle_en    = 1'b1;
    bit  sink_idle_en   = 1'b1;

    pbwt_column_update #(
        .MAX_HAPLOTYPES (MAX_HAPLOTYPES),
        .MAX_SITES      (MAX_SITES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d rows still expected",
                     cycle_count, pending_rows.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp the register to the row range the block actually uses.
    function automatic int unsigned rows_used();
        if (hap_count_reg < HAP_COUNT_MIN)
            return 32'(HAP_COUNT_MIN);
        if (hap_count_reg > MAX_HAPLOTYPES)
            return MAX_HAPLOTYPES;
        return 32'(hap_count_reg);
    endfunction

    // Store one allele; on the end-of-column transaction partition the order
    // and queue the rows the block must emit.
    task automatic predict_column_update(input logic [HAP_W-1:0] hap,
                                         input logic allele, input logic eoc);
        int unsigned      m, zeros, ones, start, p, q, dv, i;
        logic [HAP_W-1:0] id;
        logic [HAP_W-1:0] new_ord [MAX_HAPLOTYPES];
        logic [DIV_W-1:0] new_div [MAX_HAPLOTYPES];
        logic [HAP_W-1:0] one_ord [MAX_HAPLOTYPES];
        logic [DIV_W-1:0] one_div [MAX_HAPLOTYPES];
        logic [HAP_W-1:0] zb      [MAX_HAPLOTYPES];
        logic [HAP_W-1:0] ob      [MAX_HAPLOTYPES];
        t_pbwt_row        r;

        allele_mem[hap] = allele;
        if (!eoc)
            return;

        m     = rows_used();
        start = (site_cnt + 1 > MAX_SITES) ? MAX_SITES : site_cnt + 1;
        p     = start;
        q     = start;
        zeros = 0;
        ones  = 0;

        // Both running maxima advance on every row; each resets when its
        // own allele class takes a row.
        for (i = 0; i < m; i++) begin
            id    = order_mem[i];
            dv    = 32'(div_mem[i]);
            zb[i] = zeros[HAP_W-1:0];
            ob[i] = ones[HAP_W-1:0];
            if (dv > p) p = dv;
            if (dv > q) q = dv;
            if (allele_mem[id] == 1'b0) begin
                new_ord[zeros] = id;
                new_div[zeros] = p[DIV_W-1:0];
                zeros++;
                p = 0;
            end else begin
                one_ord[ones] = id;
                one_div[ones] = q[DIV_W-1:0];
                ones++;
                q = 0;
            end
        end
        for (i = 0; i < ones; i++) begin
            new_ord[zeros + i] = one_ord[i];
            new_div[zeros + i] = one_div[i];
        end

        for (i = 0; i < m; i++) begin
            order_mem[i]   = new_ord[i];
            div_mem[i]     = new_div[i];
            r.row          = i[HAP_W-1:0];
            r.hap_id       = new_ord[i];
            r.div          = new_div[i];
            r.zero_count   = zeros[CNT_W-1:0];
            r.zeros_before = zb[i];
            r.ones_before  = ob[i];
            r.is_last      = (i + 1 == m);
            pending_rows   = {pending_rows, r};
        end

        if (site_cnt < MAX_SITES)
            site_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall after each transaction, field-wise compare
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [DIV_W-1:0] want,
                                 input logic [DIV_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : row_checker
        t_pbwt_row want;
        int        stall;

        if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            rows_seen++;
            if (pending_rows.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected row, expected none, actual row %0d",
                         $time, m_axis_tdata[5:0]);
            end else begin
                want = pending_rows.pop_front();
                compare_field("row",          DIV_W'(want.row),
                              DIV_W'(m_axis_tdata[5:0]));
                compare_field("haplotype_id", DIV_W'(want.hap_id),
                              DIV_W'(m_axis_tdata[11:6]));
                compare_field("divergence",   want.div, m_axis_tdata[27:12]);
                compare_field("zero_count",   DIV_W'(want.zero_count),
                              DIV_W'(m_axis_tdata[34:28]));
                compare_field("zeros_before", DIV_W'(want.zeros_before),
                              DIV_W'(m_axis_tdata[40:35]));
                compare_field("ones_before",  DIV_W'(want.ones_before),
                              DIV_W'(m_axis_tdata[46:41]));
                compare_field("pad bit",      '0, DIV_W'(m_axis_tdata[47]));
                compare_field("last",         DIV_W'(want.is_last), DIV_W'(m_axis_tlast));
            end
            // hold ready low for the drawn number of cycles
            stall = sink_idle_en ? $urandom_range(0, 10) : 0;
            sink_stall    <= stall;
            m_axis_tready <= (stall == 0);
        end else if (sink_stall > 1) begin
            sink_stall <= sink_stall - 1;
        end else begin
            sink_stall    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Leaves tvalid high after the transaction so back-to-back items never
    // drop and re-raise it in one step; wait_for_drain lowers it.
    task automatic send_allele(input logic [HAP_W-1:0] hap, input logic allele,
                               input logic eoc);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, allele, hap};
        s_axis_tlast  <= eoc;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        allele_count++;
        predict_column_update(hap, allele, eoc);
    endtask

    // Drop the stream, wait until every predicted row is back, then let the
    // block settle.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only call while the block is drained.
    task automatic write_haplotype_count(input logic [CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        hap_count_reg  = value;
        cfg_writes++;
    endtask

    // Well-formed column: every haplotype currently in use gets an allele,
    // in shuffled order, end-of-column on the final one.
    task automatic send_full_column(input t_fill fill);
        int unsigned m, k, j, tmp;
        int unsigned perm [MAX_HAPLOTYPES];
        logic        a;

        m = rows_used();
        for (k = 0; k < m; k++)
            perm[k] = k;
        for (k = m - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (k = 0; k < m; k++) begin
            case (fill)
                FILL_ZERO:   a = 1'b0;
                FILL_ONE:    a = 1'b1;
                FILL_SPARSE: a = ($urandom_range(0, 7) == 0);
                default:     a = 1'($urandom_range(0, 1));
            endcase
            send_allele(order_mem[perm[k]], a, k == m - 1);
        end
    endtask

    // Noise: a few arbitrary haplotypes, sometimes closing a column that
    // reuses stale alleles.
    task automatic send_noise();
        int n, k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            send_allele(HAP_W'($urandom_range(0, MAX_HAPLOTYPES - 1)),
                        1'($urandom_range(0, 1)),
                        (k == n - 1) && ($urandom_range(0, 1) == 1));
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)   return CNT_W'($urandom_range(2, 8));
        if (r < 14)  return CNT_W'($urandom_range(9, MAX_HAPLOTYPES - 1));
        if (r < 16)  return CNT_W'(MAX_HAPLOTYPES);
        if (r == 16) return CNT_W'($urandom_range(0, 1));
        if (r == 17) return HAP_COUNT_MIN;
        return CNT_W'($urandom_range(MAX_HAPLOTYPES + 1, (1 << CNT_W) - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset count and identity order: load the whole panel once, so no
    // allele is ever read before it was written.
    task automatic test_reset_panel();
        int h;
        for (h = 0; h < MAX_HAPLOTYPES; h++)
            send_allele(HAP_W'(h), 1'($urandom_range(0, 1)), h == MAX_HAPLOTYPES - 1);
        wait_for_drain();
    endtask

    // Columns with a single allele class, and alternating classes.
    task automatic test_uniform_columns();
        write_haplotype_count(HAP_COUNT_MIN);
        send_full_column(FILL_ZERO);
        send_full_column(FILL_ONE);
        wait_for_drain();
        write_haplotype_count(CNT_W'(4));
        send_full_column(FILL_ONE);
        send_full_column(FILL_ZERO);
        send_allele(order_mem[0], 1'b1, 1'b0);
        send_allele(order_mem[1], 1'b0, 1'b0);
        send_allele(order_mem[2], 1'b1, 1'b0);
        send_allele(order_mem[3], 1'b0, 1'b1);
        wait_for_drain();
    endtask

    // Out-of-range counts clamp; a lone end-of-column item reuses the
    // alleles left from earlier columns.
    task automatic test_count_limits();
        write_haplotype_count(CNT_W'(0));
        send_allele(order_mem[1], 1'b1, 1'b1);
        wait_for_drain();
        write_haplotype_count(CNT_W'(1));
        send_allele(order_mem[0], 1'b0, 1'b1);
        wait_for_drain();
        write_haplotype_count(CNT_W'((1 << CNT_W) - 1));
        send_allele(order_mem[MAX_HAPLOTYPES - 1], 1'b1, 1'b1);
        wait_for_drain();
        write_haplotype_count(CNT_W'(MAX_HAPLOTYPES + 1));
        send_allele(order_mem[0], 1'b1, 1'b1);
        wait_for_drain();
        write_haplotype_count(HAP_COUNT_RESET);
        send_allele(order_mem[MAX_HAPLOTYPES - 1], 1'b0, 1'b1);
        wait_for_drain();
    endtask

    // Phases of random count and random idling, mostly well-formed columns.
    task automatic test_random_traffic();
        int first, c, ncols, r;
        first = allele_count;
        while (allele_count - first < RANDOM_ITEMS) begin
            write_haplotype_count(pick_count());
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            ncols = $urandom_range(1, 4);
            for (c = 0; c < ncols; c++) begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    send_noise();
                else if (r < 4)
                    send_full_column(FILL_SPARSE);
                else if (r == 4)
                    send_full_column($urandom_range(0, 1) ? FILL_ZERO : FILL_ONE);
                else
                    send_full_column(FILL_RANDOM);
                // sometimes hold the sender until the block has drained
                if ($urandom_range(0, 7) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        int h;
        for (h = 0; h < MAX_HAPLOTYPES; h++) begin
            allele_mem[h] = 1'b0;
            order_mem[h]  = HAP_W'(h);
            div_mem[h]    = '0;
        end
        site_cnt      = 0;
        hap_count_reg = HAP_COUNT_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_panel();
        test_uniform_columns();
        test_count_limits();
        test_random_traffic();

        wait_for_drain();
        $display("Ran %0d allele transactions and %0d result rows over %0d sites",
                 allele_count, rows_seen, site_cnt);
        $display("with %0d count writes, clamped counts and stalls on both sides included",
                 cfg_writes);
        if (mismatch_count == 0 && pending_rows.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d rows never arrived",
                     mismatch_count, pending_rows.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
